[hdl/psieve_pkg.sv]
// ----------------------------------------------------------------------------
// psieve_pkg
// shared types and constants of the prime sieve table
// ----------------------------------------------------------------------------
package psieve_pkg;

  localparam int          PSIEVE_MAX_N     = 65536;
  localparam int          PSIEVE_Q_DEPTH   = 2;
  localparam logic [15:0] PSIEVE_LIMIT_RST = 16'hFFFF;

  // opcode of an input transaction
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_BUILT = 2'd1,
    STAT_RANGE     = 2'd2
  } psieve_status_t;

  // classified item handed from front to back
  typedef struct packed {
    logic           build;
    logic           rd;
    psieve_status_t status;
    logic [15:0]    qnum;
  } psieve_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_CLR0,
    BK_CLR1,
    BK_TEST,
    BK_CHECK,
    BK_MARK,
    BK_DONE
  } psieve_state_t;

endpackage

[hdl/psieve_ram.sv]
// ----------------------------------------------------------------------------
// psieve_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module psieve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/psieve_queue.sv]
// ----------------------------------------------------------------------------
// psieve_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module psieve_queue
  import psieve_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  psieve_item_t push_item,
  output logic         full,
  input  logic         pop,
  output psieve_item_t pop_item,
  output logic         empty
);

  localparam int D  = PSIEVE_Q_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  psieve_item_t  slot_r [D];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(D));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(D - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(D - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

[hdl/psieve_front.sv]
// ----------------------------------------------------------------------------
// psieve_front
// accepts input transactions, tracks the built flag and classifies queries
// ----------------------------------------------------------------------------
module psieve_front
  import psieve_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic [15:0]  lim,
  input  logic         cfg_wr_en,
  input  logic         q_full,
  output logic         q_push,
  output psieve_item_t q_item
);

  logic built_r, built_nxt;
  logic is_build;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign is_build  = (in_tuser[0] == OP_BUILD);

  always_comb begin
    q_item.build  = is_build;
    q_item.qnum   = in_tdata;
    q_item.rd     = 1'b0;
    q_item.status = STAT_OK;
    if (!is_build) begin
      if (!built_r) begin
        q_item.status = STAT_NOT_BUILT;
      end else if (in_tdata > lim) begin
        q_item.status = STAT_RANGE;
      end else begin
        q_item.rd = 1'b1;
      end
    end
  end

  // a build in the queue makes later queries see a built map
  always_comb begin
    built_nxt = built_r;
    if (cfg_wr_en) begin
      built_nxt = 1'b0;
    end else if (q_push && is_build) begin
      built_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r <= 1'b0;
    end else begin
      built_r <= built_nxt;
    end
  end

endmodule

[hdl/psieve_back.sv]
// ----------------------------------------------------------------------------
// psieve_back
// runs builds on the prime map ram and answers queries through a read stage
// ----------------------------------------------------------------------------
module psieve_back
  import psieve_pkg::*;
#(
  parameter int MAX_N = PSIEVE_MAX_N
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [15:0]  lim,
  input  logic         q_empty,
  input  psieve_item_t q_head,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_is_prime,
  output logic [1:0]   out_status
);

  localparam int AW = $clog2(MAX_N);

  psieve_state_t state_r, state_nxt;

  logic [15:0] k_r;
  logic [8:0]  i_r;
  logic [16:0] sq_r;
  logic [16:0] j_r;
  logic [16:0] lim_x;

  logic          p1_v_r, p1_rd_r;
  psieve_status_t p1_stat_r;
  logic          out_v_r, out_prime_r;
  psieve_status_t out_stat_r;

  logic          out_free, p1_can;
  logic          p1_load, p1_load_rd;
  psieve_status_t p1_load_stat;

  logic          ram_we, ram_wd, ram_re, ram_rd;
  logic [AW-1:0] ram_wa, ram_ra;

  assign lim_x    = {1'b0, lim};
  assign out_free = !out_v_r || out_tready;
  assign p1_can   = !p1_v_r || out_free;

  psieve_ram #(
    .WIDTH (1),
    .DEPTH (MAX_N)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && q_head.build && !p1_v_r) begin
          state_nxt = BK_FILL;
        end
      end
      BK_FILL: begin
        if (k_r == lim) begin
          state_nxt = BK_CLR0;
        end
      end
      BK_CLR0: state_nxt = BK_CLR1;
      BK_CLR1: state_nxt = BK_TEST;
      BK_TEST: begin
        state_nxt = (sq_r > lim_x) ? BK_DONE : BK_CHECK;
      end
      BK_CHECK: begin
        state_nxt = ram_rd ? BK_MARK : BK_TEST;
      end
      BK_MARK: begin
        if (j_r > lim_x) begin
          state_nxt = BK_TEST;
        end
      end
      BK_DONE: begin
        if (p1_can) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_wa       = '0;
    ram_wd       = 1'b0;
    ram_re       = 1'b0;
    ram_ra       = '0;
    p1_load      = 1'b0;
    p1_load_rd   = 1'b0;
    p1_load_stat = STAT_OK;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.build) begin
            q_pop = !p1_v_r;
          end else if (p1_can) begin
            q_pop        = 1'b1;
            p1_load      = 1'b1;
            p1_load_rd   = q_head.rd;
            p1_load_stat = q_head.status;
            ram_re       = q_head.rd;
            ram_ra       = AW'(q_head.qnum);
          end
        end
      end
      BK_FILL: begin
        ram_we = 1'b1;
        ram_wa = AW'(k_r);
        ram_wd = 1'b1;
      end
      BK_CLR0: begin
        ram_we = 1'b1;
        ram_wa = AW'(0);
      end
      BK_CLR1: begin
        ram_we = 1'b1;
        ram_wa = AW'(1);
      end
      BK_TEST: begin
        ram_re = 1'b1;
        ram_ra = AW'(i_r);
      end
      BK_MARK: begin
        if (j_r <= lim_x) begin
          ram_we = 1'b1;
          ram_wa = AW'(j_r);
        end
      end
      BK_DONE: begin
        p1_load = p1_can;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sieve counters; squares advance by 2i+1
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: k_r <= '0;
      BK_FILL: k_r <= k_r + 1'b1;
      BK_CLR1: begin
        i_r  <= 9'd2;
        sq_r <= 17'd4;
      end
      BK_CHECK: begin
        if (ram_rd) begin
          j_r <= sq_r;
        end else begin
          i_r  <= i_r + 1'b1;
          sq_r <= sq_r + 17'({i_r, 1'b1});
        end
      end
      BK_MARK: begin
        if (j_r <= lim_x) begin
          j_r <= j_r + 17'(i_r);
        end else begin
          i_r  <= i_r + 1'b1;
          sq_r <= sq_r + 17'({i_r, 1'b1});
        end
      end
      default: ;
    endcase
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_r <= p1_v_r;
      end
      if (p1_can) begin
        p1_v_r <= p1_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_prime_r <= p1_rd_r & ram_rd;
      out_stat_r  <= p1_stat_r;
    end
    if (p1_can) begin
      p1_rd_r   <= p1_load_rd;
      p1_stat_r <= p1_load_stat;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_is_prime = out_prime_r;
  assign out_status   = out_stat_r;

endmodule

[hdl/prime_sieve_table.sv]
// ----------------------------------------------------------------------------
// prime_sieve_table
// one-bit primality map over 0..limit, built by a sieve and read by queries
// ----------------------------------------------------------------------------
// A build transaction (tuser 0) fills the map, clears 0 and 1 and strikes out
// multiples of every remaining number up to the square root of the limit; it
// answers is_prime 0, status ok. A query transaction (tuser 1) returns the map
// bit of the number in tdata, with status not built before any build (or after
// a limit write) and status out of range above the limit. Queries stream at
// one per cycle while the result stream and queue do not stall, since each is
// a single read of the map ram; a result passes the queue, the read stage and
// the output register. A build runs on the map ram's single write port and
// holds off later transactions while it runs: it fills the map up to the
// limit, clears the seeds 0 and 1, tests each candidate up to the square root
// of the limit and strikes out the multiples of each prime. Transactions are
// classified in the front and queued, so input acceptance continues while the
// back end finishes earlier work, until the queue is full. The effective
// limit is the written limit capped at MAX_N-1; write it only while the block
// is idle.
// ----------------------------------------------------------------------------
module prime_sieve_table
  import psieve_pkg::*;
#(
  parameter int MAX_N = PSIEVE_MAX_N
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] query_number
  input  logic [0:0]  in_tuser,   // [0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] is_prime, [7:1] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // limit register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // reset limit, capped to the map size
  localparam logic [15:0] LIM_RST =
    (MAX_N - 1 > int'(PSIEVE_LIMIT_RST)) ? PSIEVE_LIMIT_RST : 16'(MAX_N - 1);

  logic [15:0]  lim_r, lim_nxt;
  logic         q_push, q_pop, q_full, q_empty;
  psieve_item_t q_in, q_head;
  logic         res_prime;
  logic [1:0]   res_status;

  // effective limit kept in the register
  always_comb begin
    lim_nxt = lim_r;
    if (cfg_wr_en) begin
      lim_nxt = (32'(cfg_wr_data) > 32'(MAX_N - 1)) ? 16'(MAX_N - 1) : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RST;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  // front: accept and classify
  psieve_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .lim       (lim_r),
    .cfg_wr_en (cfg_wr_en),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // queue between front and back
  psieve_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_head),
    .empty     (q_empty)
  );

  // back: build sequencer, map ram and result path
  psieve_back #(
    .MAX_N (MAX_N)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .lim          (lim_r),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_is_prime (res_prime),
    .out_status   (res_status)
  );

  assign out_tdata = {7'b0, res_prime};
  assign out_tuser = res_status;

endmodule

[dv/prime_sieve_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_table_tb
// self-checking stream testbench for the prime sieve table
// ----------------------------------------------------------------------------
// A queue of pending transactions feeds a clocked driver on the input stream.
// Every accepted transaction goes through a local sieve predictor. The
// predicted answers wait in order for the result stream, and a monitor checks
// them there. A directed part covers queries before any build, the lowest and
// highest limits and back-to-back builds. It also covers a limit rewrite that
// drops the map. Random phases follow, each with its own limit, a build and
// then mostly queries. Both sides idle at random. One phase holds the
// receiver off long enough to fill the block. Another phase pauses the sender
// until the block drains. A third runs with no idling at all.
// ----------------------------------------------------------------------------
module prime_sieve_table_tb;
  import psieve_pkg::*;

  localparam int          IDLE_PCT         = 29;      // idle chance per cycle, percent
  localparam int unsigned WATCHDOG_LIMIT   = 1000000; // quiet-cycle limit, above a full 16-bit build
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES    = 16;      // quiet cycles before a limit write
  localparam int          RANDOM_PHASES    = 8;
  localparam int          RANDOM_ITEMS     = 1650;
  localparam int          MAX_REPORTS      = 10;

  // one input transaction
  typedef struct {
    logic        op;
    logic [15:0] num;
  } sieve_req_t;

  // one predicted result transaction
  typedef struct {
    logic           is_prime;
    psieve_status_t status;
  } sieve_answer_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;     // [15:0] query_number
  logic [0:0]  in_tuser    = '0;     // [0] opcode
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;            // [0] is_prime, [7:1] zero
  logic [1:0]  out_tuser;            // [1:0] status
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = PSIEVE_LIMIT_RST;

  // predictor state: map, built flag and limit register
  bit          sieve_bits [PSIEVE_MAX_N];
  bit          sieve_ready = 1'b0;
  logic [15:0] sieve_limit = PSIEVE_LIMIT_RST;

  sieve_req_t    items_to_send [$];
  sieve_answer_t answers_due   [$];

  sieve_req_t    head_req;
  sieve_req_t    seen_req;
  sieve_answer_t due;

  bit          no_idle       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int          fail_count    = 0;

  prime_sieve_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // written limit, capped to the map size
  function automatic int unsigned sieve_top();
    int unsigned lim;
    lim = 32'(sieve_limit);
    if (lim > PSIEVE_MAX_N - 1) begin
      lim = PSIEVE_MAX_N - 1;
    end
    return lim;
  endfunction

  // eratosthenes up to the square root of the limit
  function automatic void rebuild_sieve();
    int unsigned lim;
    int unsigned i;
    int unsigned j;
    lim = sieve_top();
    foreach (sieve_bits[k]) begin
      sieve_bits[k] = 1'b1;
    end
    sieve_bits[0] = 1'b0;
    sieve_bits[1] = 1'b0;
    for (i = 2; i * i <= lim; i++) begin
      if (sieve_bits[i]) begin
        for (j = i * i; j <= lim; j += i) begin
          sieve_bits[j] = 1'b0;
        end
      end
    end
    sieve_ready = 1'b1;
  endfunction

  // answer for one accepted transaction; a build updates the map
  function automatic sieve_answer_t answer_for(sieve_req_t req);
    sieve_answer_t ans;
    ans.is_prime = 1'b0;
    ans.status   = STAT_OK;
    if (req.op == OP_BUILD) begin
      rebuild_sieve();
    end else if (!sieve_ready) begin
      // not built wins over the range check
      ans.status = STAT_NOT_BUILT;
    end else if (req.num > sieve_top()) begin
      ans.status = STAT_RANGE;
    end else begin
      ans.is_prime = sieve_bits[req.num];
    end
    return ans;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endfunction

  // ------------------------------------------------------------------------
  // input driver: one transaction at a time from the pending queue
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // slot is free: offer the next transaction unless idling
      if (items_to_send.size() != 0 && (no_idle || $urandom_range(99, 0) >= IDLE_PCT)) begin
        head_req = items_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= head_req.num;
        in_tuser  <= head_req.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // result receiver: random backpressure plus long hold-offs on request
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = SINK_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------------------
  // monitor: check results first, then predict for the input transaction
  // accepted at the same edge, so the order within one edge is fixed
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          note_failure($sformatf("unexpected result tdata %0h tuser %0d",
                                 out_tdata, out_tuser));
        end else begin
          due = answers_due.pop_front();
          if (out_tdata !== {7'b0, due.is_prime} || out_tuser !== due.status) begin
            note_failure($sformatf("is_prime exp %0b got tdata %0h, status exp %0d got %0d",
                                   due.is_prime, out_tdata, due.status, out_tuser));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        seen_req.op  = in_tuser[0];
        seen_req.num = in_tdata;
        answers_due.push_back(answer_for(seen_req));
      end
    end
  end

  // watchdog: cycles with no transaction on any port
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("prime_sieve_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  function automatic void send(logic op, logic [15:0] num);
    sieve_req_t r;
    r.op  = op;
    r.num = num;
    items_to_send.push_back(r);
  endfunction

  // mostly in range, some right at or above the limit, some anywhere
  function automatic logic [15:0] pick_query(int unsigned lim);
    int unsigned roll;
    int unsigned near_num;
    roll = $urandom_range(99, 0);
    if (roll < 60) begin
      return 16'($urandom_range(lim, 0));
    end
    if (roll < 75) begin
      near_num = lim + $urandom_range(3, 0);
      return (near_num > 65535) ? 16'hFFFF : near_num[15:0];
    end
    return 16'($urandom_range(65535, 0));
  endfunction

  // everything sent and answered
  task automatic wait_drained();
    while (items_to_send.size() != 0 || in_tvalid || answers_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // limit write while idle, tracked in the predictor as the write is driven
  task automatic write_limit(logic [15:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sieve_limit = value;
    sieve_ready = 1'b0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned lim;
    int unsigned roll;
    int          per_phase;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // queries right after reset find no map
    send(OP_QUERY, 16'd0);
    send(OP_QUERY, 16'hFFFF);

    // smallest limit
    write_limit(16'd2);
    send(OP_QUERY, 16'd2);
    send(OP_BUILD, 16'hFFFF);
    send(OP_QUERY, 16'd0);
    send(OP_QUERY, 16'd1);
    send(OP_QUERY, 16'd2);
    send(OP_QUERY, 16'd3);
    send(OP_QUERY, 16'hFFFF);

    // back-to-back builds on a small map
    write_limit(16'd30);
    send(OP_BUILD, 16'd0);
    send(OP_BUILD, 16'h5A5A);
    send(OP_QUERY, 16'd29);
    send(OP_QUERY, 16'd30);
    send(OP_QUERY, 16'd31);
    send(OP_QUERY, 16'd25);
    send(OP_QUERY, 16'd4);

    // full 16-bit map, the one long build of the run
    write_limit(16'hFFFF);
    send(OP_BUILD, 16'd0);
    send(OP_QUERY, 16'd65521);
    send(OP_QUERY, 16'hFFFF);
    send(OP_QUERY, 16'hFFFE);
    send(OP_QUERY, 16'd2);
    send(OP_QUERY, 16'd1);
    send(OP_QUERY, 16'd32749);

    // rewriting the same limit still drops the map
    write_limit(16'hFFFF);
    send(OP_QUERY, 16'd65521);

    // --- random phases ---
    per_phase = RANDOM_ITEMS / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      roll = $urandom_range(99, 0);
      if (p == 0) begin
        lim = 2;
      end else if (roll < 50) begin
        lim = $urandom_range(300, 2);
      end else if (roll < 85) begin
        lim = $urandom_range(3000, 301);
      end else begin
        lim = $urandom_range(12000, 3001);
      end
      write_limit(lim[15:0]);
      if (p == 2) begin
        no_idle = 1'b1;
      end

      // now and then a few queries before the build
      if ($urandom_range(9, 0) == 0) begin
        repeat ($urandom_range(4, 1)) send(OP_QUERY, pick_query(lim));
      end
      send(OP_BUILD, 16'($urandom_range(65535, 0)));

      for (int k = 1; k < per_phase; k++) begin
        if (k == per_phase / 2) begin
          if (p == 0) begin
            // long receiver hold-off while the sender keeps offering
            hold_requests++;
          end else if (p == 1) begin
            // sender pauses until every answer is back
            wait_drained();
            repeat ($urandom_range(60, 20)) @(negedge clk);
          end
        end
        // extra rebuilds only on cheap maps; a phase ends on a query
        if (k < per_phase - 1 && lim <= 3000 && $urandom_range(99, 0) < 2) begin
          send(OP_BUILD, 16'($urandom_range(65535, 0)));
        end else begin
          send(OP_QUERY, pick_query(lim));
        end
      end
      wait_drained();
      no_idle = 1'b0;
    end

    // --- end of run ---
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("prime_sieve_table regression: pass");
    end else begin
      $display("prime_sieve_table regression: fail");
    end
    $finish;
  end

endmodule
